// ===== hw/rtl/lds_pkg.sv =====
// Shared types and constants for the Laplace direct-summation block.
// Used by controller, datapath, top level and checker; depends on nothing.
`default_nettype none

package lds_pkg;

  // Default capacity of the source store.
  localparam int MAX_SOURCES_DEF = 1024;

  // One stored source: {charge, z, y, x}, 32 bits each.
  localparam int SRC_W = 128;

  // round(2^32 / (4*pi)).
  localparam logic [28:0] COEF_Q32 = 29'd341782638;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_EVAL   = 2'd2
  } cmd_t;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_LOAD, ST_SQ, ST_SQF, ST_CHK, ST_NORM, ST_SQRT,
    ST_PDI, ST_PDIV, ST_PACC, ST_GLO, ST_GHI, ST_GSUM, ST_GDI, ST_GDIV,
    ST_GACC, ST_NEXT, ST_FIN
  } state_t;

  // Datapath operations, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE, OP_TARGET, OP_LOAD, OP_SQ, OP_SQF, OP_NORM_INIT, OP_NORM,
    OP_SQRT_INIT, OP_SQRT, OP_PDIV_INIT, OP_DIV, OP_PACC, OP_GLO, OP_GHI,
    OP_GSUM, OP_GDIV_INIT, OP_GACC, OP_OUT
  } op_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic       dropped;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic r2_zero;
    logic norm_done;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lds_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// Stand-alone; no package needed.
`default_nettype none

module lds_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lds_ctrl.sv =====
// Sequencer of the direct-summation block: command decode, source store
// bookkeeping and the per-source operation sequence. Uses lds_pkg.
`default_nettype none

module lds_ctrl #(
  parameter int MAX_SOURCES = lds_pkg::MAX_SOURCES_DEF,
  localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_cmd,
  output logic                     ram_we,
  output logic [AW-1:0]            ram_waddr,
  output logic [AW-1:0]            ram_raddr,
  output lds_pkg::dp_cmd_t         dp_cmd,
  input  wire lds_pkg::dp_status_t dp_status
);

  import lds_pkg::*;

  localparam int CW = $clog2(MAX_SOURCES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SOURCES);

  state_t        state_r, state_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic          grad_en_r;
  logic          in_acc;
  // Gradient axis, held while the divider uses the counter.
  logic [1:0]    gaxis_r;

  assign in_acc    = in_valid & ~in_stall;
  assign ram_waddr = count_r[AW-1:0];
  assign ram_raddr = idx_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      idx_r     <= '0;
      count_r   <= '0;
      dropped_r <= 1'b0;
      grad_en_r <= 1'b1;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      if (cfg_wr_en) begin
        grad_en_r <= cfg_wr_data;
      end
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    count_nxt       = count_r;
    dropped_nxt     = dropped_r;
    in_stall        = (state_r != ST_IDLE);
    ram_we          = 1'b0;
    dp_cmd.op       = OP_NONE;
    dp_cmd.axis     = cnt_r[1:0];
    dp_cmd.dropped  = dropped_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_CLEAR: begin
              count_nxt   = '0;
              dropped_nxt = 1'b0;
            end
            CMD_APPEND: begin
              if (count_r < MAX_CNT) begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            CMD_EVAL: begin
              dp_cmd.op = OP_TARGET;
              idx_nxt   = '0;
              state_nxt = (count_r == '0) ? ST_FIN : ST_RD;
            end
            default: ;
          endcase
        end
      end
      // RAM read of the current source is in flight.
      ST_RD: state_nxt = ST_LOAD;
      ST_LOAD: begin
        dp_cmd.op = OP_LOAD;
        cnt_nxt   = '0;
        state_nxt = ST_SQ;
      end
      // One squared axis per cycle through the shared multiplier.
      ST_SQ: begin
        dp_cmd.op = OP_SQ;
        cnt_nxt   = cnt_r + 6'd1;
        if (cnt_r == 6'd2) begin
          state_nxt = ST_SQF;
        end
      end
      ST_SQF: begin
        dp_cmd.op = OP_SQF;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (dp_status.r2_zero) begin
          state_nxt = ST_NEXT;
        end else begin
          dp_cmd.op = OP_NORM_INIT;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (dp_status.norm_done) begin
          dp_cmd.op = OP_SQRT_INIT;
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end else begin
          dp_cmd.op = OP_NORM;
        end
      end
      ST_SQRT: begin
        dp_cmd.op = OP_SQRT;
        cnt_nxt   = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          state_nxt = ST_PDI;
        end
      end
      ST_PDI: begin
        dp_cmd.op = OP_PDIV_INIT;
        cnt_nxt   = '0;
        state_nxt = ST_PDIV;
      end
      ST_PDIV: begin
        dp_cmd.op = OP_DIV;
        cnt_nxt   = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = ST_PACC;
        end
      end
      ST_PACC: begin
        dp_cmd.op = OP_PACC;
        cnt_nxt   = '0;
        state_nxt = grad_en_r ? ST_GLO : ST_NEXT;
      end
      // Gradient: cnt_r holds the axis until the divider starts.
      ST_GLO: begin
        dp_cmd.op = OP_GLO;
        state_nxt = ST_GHI;
      end
      ST_GHI: begin
        dp_cmd.op = OP_GHI;
        state_nxt = ST_GSUM;
      end
      ST_GSUM: begin
        dp_cmd.op = OP_GSUM;
        state_nxt = ST_GDI;
      end
      ST_GDI: begin
        dp_cmd.op = OP_GDIV_INIT;
        cnt_nxt   = '0;
        state_nxt = ST_GDIV;
      end
      // The divider counts 64 steps while the axis waits in gaxis_r.
      ST_GDIV: begin
        dp_cmd.op   = OP_DIV;
        dp_cmd.axis = gaxis_r;
        cnt_nxt     = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = ST_GACC;
        end
      end
      ST_GACC: begin
        dp_cmd.op   = OP_GACC;
        dp_cmd.axis = gaxis_r;
        cnt_nxt     = 6'(gaxis_r) + 6'd1;
        state_nxt   = (gaxis_r == 2'd2) ? ST_NEXT : ST_GLO;
      end
      ST_NEXT: begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ((CW'(idx_r) + 1'b1) == count_r) ? ST_FIN : ST_RD;
      end
      ST_FIN: begin
        if (!dp_status.out_busy) begin
          dp_cmd.op = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Axis register, loaded when the gradient divide starts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gaxis_r <= '0;
    end else if (state_r == ST_GDI) begin
      gaxis_r <= cnt_r[1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lds_datapath.sv =====
// Arithmetic datapath: differences, squared distance, normalizer, bit-serial
// square root, restoring divider, accumulators and result word. Uses lds_pkg.
`default_nettype none

module lds_datapath #(
  parameter int MAX_SOURCES = lds_pkg::MAX_SOURCES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lds_pkg::dp_cmd_t               dp_cmd,
  output lds_pkg::dp_status_t                 dp_status,
  input  wire logic signed [31:0]             in_pos_x,
  input  wire logic signed [31:0]             in_pos_y,
  input  wire logic signed [31:0]             in_pos_z,
  input  wire logic [lds_pkg::SRC_W-1:0]      ram_rdata,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [47:0]                  out_potential,
  output logic signed [47:0]                  out_grad_x,
  output logic signed [47:0]                  out_grad_y,
  output logic signed [47:0]                  out_grad_z,
  output logic                                out_overflow_seen
);

  import lds_pkg::*;

  localparam int ACC_W = 50 + $clog2(MAX_SOURCES);
  localparam logic [63:0] MAG_POS = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] MAG_NEG = 64'h0000_8000_0000_0000;
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(MAG_POS);
  localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI - 1;

  // Saturated signed term of one magnitude.
  function automatic logic signed [48:0] term(input logic [63:0] mag, input logic neg);
    logic [47:0] lim;
    if (neg) begin
      lim = (mag > MAG_NEG) ? MAG_NEG[47:0] : mag[47:0];
      return -$signed({1'b0, lim});
    end
    lim = (mag > MAG_POS) ? MAG_POS[47:0] : mag[47:0];
    return $signed({1'b0, lim});
  endfunction

  // Clamp an accumulator to the 48-bit result range.
  function automatic logic signed [47:0] sat48(input logic signed [ACC_W-1:0] v);
    if (v > ACC_HI) return 48'sh7FFF_FFFF_FFFF;
    if (v < ACC_LO) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  logic signed [31:0] tgt_r [3];
  logic [32:0]        ad_r [3];
  logic               dneg_r [3];
  logic               qneg_r;
  logic [31:0]        aq_r;
  logic [65:0]        r2_r;
  logic [65:0]        prod_r;
  logic [63:0]        m_r;
  logic signed [5:0]  h_r;
  logic [59:0]        a_r;
  logic [63:0]        sq_x_r, sq_res_r, sq_bit_r;
  logic [63:0]        div_rem_r, div_lo_r, div_q_r, div_d_r;
  logic               div_sat_r;
  logic [63:0]        p_r, ss_r;
  logic [96:0]        n_r;
  logic signed [ACC_W-1:0] acc_r [4];
  logic               out_valid_r;
  logic signed [47:0] pot_r, gx_r, gy_r, gz_r;
  logic               ovf_r;

  logic signed [31:0] src [3];
  logic [32:0]        diff [3];
  logic [32:0]        dabs [3];
  logic [31:0]        q_w, qabs;
  logic [32:0]        mul_a, mul_b;
  logic [65:0]        prod_nxt;
  logic [63:0]        sq_trial;
  logic [63:0]        div_shift, div_sub;
  logic               div_ge;
  logic [127:0]       pot_num, div_num;
  logic [63:0]        pot_den, div_den;
  logic [6:0]         g_sh;
  logic [183:0]       g_wide;
  logic               g_ovf, div_ovf;
  logic [63:0]        quot;
  logic [1:0]         gidx;

  // Source fields and differences to the target.
  always_comb begin
    src[0] = ram_rdata[31:0];
    src[1] = ram_rdata[63:32];
    src[2] = ram_rdata[95:64];
    q_w    = ram_rdata[127:96];
    qabs   = q_w[31] ? (~q_w + 32'd1) : q_w;
    for (int k = 0; k < 3; k++) begin
      diff[k] = {tgt_r[k][31], tgt_r[k]} - {src[k][31], src[k]};
      dabs[k] = diff[k][32] ? (~diff[k] + 33'd1) : diff[k];
    end
  end

  // Shared 33x33 multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (dp_cmd.op)
      OP_SQ: begin
        mul_a = ad_r[dp_cmd.axis];
        mul_b = ad_r[dp_cmd.axis];
      end
      OP_NORM_INIT: begin
        mul_a = {1'b0, aq_r};
        mul_b = 33'(COEF_Q32);
      end
      OP_PDIV_INIT: begin
        mul_a = {1'b0, sq_res_r[31:0]};
        mul_b = {1'b0, sq_res_r[31:0]};
      end
      OP_GLO: begin
        mul_a = {1'b0, p_r[31:0]};
        mul_b = ad_r[dp_cmd.axis];
      end
      OP_GHI: begin
        mul_a = {1'b0, p_r[63:32]};
        mul_b = ad_r[dp_cmd.axis];
      end
      default: ;
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Square root trial, divider step and divider setup.
  always_comb begin
    sq_trial  = sq_res_r + sq_bit_r;
    div_shift = {div_rem_r[62:0], div_lo_r[63]};
    div_ge    = div_rem_r[63] | (div_shift >= div_d_r);
    div_sub   = div_shift - div_d_r;
    pot_num   = h_r[5] ? {68'd0, a_r} : ({68'd0, a_r} << h_r[4:0]);
    pot_den   = h_r[5] ? {31'd0, sq_res_r[31:0], 1'b0} : {32'd0, sq_res_r[31:0]};
    g_sh      = 7'd24 + {h_r, 1'b0};
    g_wide    = {87'd0, n_r} << g_sh;
    // A shifted numerator reaching bit 127 saturates the gradient term.
    g_ovf     = |g_wide[183:127];
    if (dp_cmd.op == OP_PDIV_INIT) begin
      div_num = pot_num;
      div_den = pot_den;
      div_ovf = 1'b0;
    end else begin
      div_num = g_wide[127:0];
      div_den = ss_r;
      div_ovf = g_ovf;
    end
    quot = div_sat_r ? '1 : div_q_r;
    gidx = 2'(dp_cmd.axis + 2'd1);
  end

  // Datapath registers, one operation per cycle.
  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      OP_TARGET: begin
        tgt_r[0] <= in_pos_x;
        tgt_r[1] <= in_pos_y;
        tgt_r[2] <= in_pos_z;
        for (int k = 0; k < 4; k++) begin
          acc_r[k] <= '0;
        end
      end
      OP_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          ad_r[k]   <= dabs[k];
          dneg_r[k] <= diff[k][32];
        end
        qneg_r <= q_w[31];
        aq_r   <= qabs;
        r2_r   <= '0;
        prod_r <= '0;
      end
      OP_SQ: begin
        r2_r   <= r2_r + prod_r;
        prod_r <= prod_nxt;
      end
      OP_SQF: r2_r <= r2_r + prod_r;
      OP_NORM_INIT: begin
        if (|r2_r[65:64]) begin
          m_r <= r2_r[65:2];
          h_r <= -6'sd1;
        end else begin
          m_r <= r2_r[63:0];
          h_r <= 6'sd0;
        end
        prod_r <= prod_nxt;
      end
      OP_NORM: begin
        m_r <= {m_r[61:0], 2'b00};
        h_r <= h_r + 6'sd1;
      end
      OP_SQRT_INIT: begin
        sq_x_r   <= m_r;
        sq_res_r <= '0;
        sq_bit_r <= 64'h4000_0000_0000_0000;
        a_r      <= prod_r[59:0];
      end
      OP_SQRT: begin
        if (sq_x_r >= sq_trial) begin
          sq_x_r   <= sq_x_r - sq_trial;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_PDIV_INIT, OP_GDIV_INIT: begin
        div_rem_r <= div_num[127:64];
        div_lo_r  <= div_num[63:0];
        div_d_r   <= div_den;
        div_q_r   <= '0;
        div_sat_r <= div_ovf | (div_num[127:64] >= div_den);
        if (dp_cmd.op == OP_PDIV_INIT) begin
          prod_r <= prod_nxt;
        end
      end
      OP_DIV: begin
        div_rem_r <= div_ge ? div_sub : div_shift;
        div_lo_r  <= {div_lo_r[62:0], 1'b0};
        div_q_r   <= {div_q_r[62:0], div_ge};
      end
      OP_PACC: begin
        p_r      <= quot;
        ss_r     <= prod_r[63:0];
        acc_r[0] <= acc_r[0] + ACC_W'(term(quot, qneg_r));
      end
      OP_GLO: prod_r <= prod_nxt;
      OP_GHI: begin
        prod_r <= prod_nxt;
        n_r    <= 97'(prod_r);
      end
      OP_GSUM: n_r <= n_r + {prod_r[64:0], 32'd0};
      OP_GACC: begin
        acc_r[gidx] <= acc_r[gidx] +
                       ACC_W'(term(quot, qneg_r == dneg_r[dp_cmd.axis]));
      end
      OP_OUT: begin
        pot_r <= sat48(acc_r[0]);
        gx_r  <= sat48(acc_r[1]);
        gy_r  <= sat48(acc_r[2]);
        gz_r  <= sat48(acc_r[3]);
        ovf_r <= dp_cmd.dropped;
      end
      default: ;
    endcase
  end

  // Result word valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign dp_status.r2_zero   = (r2_r == '0);
  assign dp_status.norm_done = |m_r[63:62];
  assign dp_status.out_busy  = out_valid_r & out_stall;

  assign out_valid         = out_valid_r;
  assign out_potential     = pot_r;
  assign out_grad_x        = gx_r;
  assign out_grad_y        = gy_r;
  assign out_grad_z        = gz_r;
  assign out_overflow_seen = ovf_r;

endmodule

`default_nettype wire

// ===== hw/rtl/laplace_direct_sum.sv =====
// Top level of the Laplace direct-summation block: source store RAM,
// sequencer and datapath. Uses lds_pkg, lds_ram, lds_ctrl, lds_datapath.
`default_nettype none

// Direct particle-to-particle Laplace kernel. Clear and append words are
// taken without stalling the input. An evaluate word walks the stored
// sources one at a time with a shared multiplier, a 32-step square root
// and a 64-step divider: a coincident source is skipped, any other source
// adds its potential and, with the gradient on, its gradient. The squared
// distance is normalized by 0 to 31 two-bit shifts. Input is stalled while
// an evaluation runs; the result word is held in an output register, so
// clear and append words are taken while it waits. The store needs no
// clearing.
module laplace_direct_sum #(
  parameter int MAX_SOURCES = lds_pkg::MAX_SOURCES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_cmd,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_charge,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [47:0]      out_potential,
  output logic signed [47:0]      out_grad_x,
  output logic signed [47:0]      out_grad_y,
  output logic signed [47:0]      out_grad_z,
  output logic                    out_overflow_seen
);

  import lds_pkg::*;

  localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [SRC_W-1:0] ram_rdata;
  dp_cmd_t          dp_cmd;
  dp_status_t       dp_status;

  // Source store: {charge, z, y, x}.
  lds_ram #(
    .WIDTH (SRC_W),
    .DEPTH (MAX_SOURCES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_charge, in_pos_z, in_pos_y, in_pos_x}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer.
  lds_ctrl #(
    .MAX_SOURCES (MAX_SOURCES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_raddr   (ram_raddr),
    .dp_cmd      (dp_cmd),
    .dp_status   (dp_status)
  );

  // Arithmetic.
  lds_datapath #(
    .MAX_SOURCES (MAX_SOURCES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .dp_cmd            (dp_cmd),
    .dp_status         (dp_status),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .ram_rdata         (ram_rdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_potential     (out_potential),
    .out_grad_x        (out_grad_x),
    .out_grad_y        (out_grad_y),
    .out_grad_z        (out_grad_z),
    .out_overflow_seen (out_overflow_seen)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lds_checker.sv =====
// Port-level checks for the Laplace direct-summation block, bound to the
// top level. Uses lds_pkg and sees laplace_direct_sum only through its ports.
`default_nettype none

module lds_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [1:0]         in_cmd,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [47:0] out_potential
);

  import lds_pkg::*;

  // No result word right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_potential))
    else $error("stalled result word changed");

  // An accepted evaluate word starts a busy phase.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == CMD_EVAL |=> in_stall)
    else $error("evaluate did not stall input");

  // Other words do not stall the input in the following cycle.
  a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd != CMD_EVAL |=> !in_stall)
    else $error("store command stalled input");

  // A new result comes only out of a busy phase.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without evaluation");

endmodule

bind laplace_direct_sum lds_checker u_lds_checker (.*);

`default_nettype wire
